// ----- src/ssp_pkg.sv -----
// Shared types and constants of the spiral sphere point generator.
package ssp_pkg;

	// Configuration register indexes
	localparam logic [2:0] CFG_RESOLUTION = 3'd0;
	localparam logic [2:0] CFG_RADIUS     = 3'd1;
	localparam logic [2:0] CFG_CENTER_X   = 3'd2;
	localparam logic [2:0] CFG_CENTER_Y   = 3'd3;
	localparam logic [2:0] CFG_CENTER_Z   = 3'd4;

	// Resolution limits
	localparam logic [7:0] MIN_RESOLUTION = 8'd4;
	localparam logic [7:0] MAX_RESOLUTION = 8'd255;

	// Azimuth step gain: 1.8 turns-per-radian scale in 2^32 units of a turn
	localparam logic [31:0] AZ_STEP_K = 32'd1230417496;

	// Odd sine polynomial coefficients, Q30, on a quarter turn
	localparam logic [31:0] SIN_A = 32'd1686629713;
	localparam logic [31:0] SIN_B = 32'd693598668;
	localparam logic [31:0] SIN_C = 32'd85569306;
	localparam logic [31:0] SIN_D = 32'd5026995;
	localparam logic [31:0] SIN_E = 32'd172272;

	localparam logic [30:0] Q30_ONE = 31'h4000_0000;

	// Iteration counts of the divide / square-root unit
	localparam logic [6:0] SQRT_ITERS   = 7'd32;
	localparam logic [6:0] DIV_AZ_ITERS = 7'd55;
	localparam logic [6:0] DIV_Q_ITERS  = 7'd46;

	// Command to the shared divide / square-root unit
	typedef struct packed {
		logic        start;
		logic        is_sqrt;
		logic [6:0]  count;
		logic [63:0] a;
		logic [31:0] b;
	} dsq_cmd_t;

endpackage

// ----- src/ssp_divsqrt.sv -----
// Shared bit-serial unsigned divider and integer square root.
module ssp_divsqrt (
	input  logic              clk,
	input  logic              arst_n,
	input  ssp_pkg::dsq_cmd_t cmd,
	output logic              done,
	output logic [63:0]       result
);
	import ssp_pkg::*;

	logic        busy_q;
	logic        done_q;
	logic        sqrt_q;
	logic [6:0]  cnt_q;
	logic [63:0] x_q;
	logic [63:0] y_q;
	logic [63:0] bit_q;
	logic [31:0] rem_q;
	logic [31:0] b_q;

	logic [32:0] rem_sh;
	logic        div_ge;
	logic [32:0] rem_nx;
	logic [63:0] trial;
	logic        sq_ge;

	// One restoring divide step and one square-root digit step
	always_comb begin
		rem_sh = {rem_q, x_q[63]};
		div_ge = rem_sh >= {1'b0, b_q};
		rem_nx = div_ge ? rem_sh - {1'b0, b_q} : rem_sh;
		trial  = y_q + bit_q;
		sq_ge  = x_q >= trial;
	end

	// Control: count iterations, flag completion
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				busy_q <= 1'b1;
				cnt_q  <= cmd.count;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: load operands, advance one bit per cycle
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			sqrt_q <= cmd.is_sqrt;
			x_q    <= cmd.a;
			b_q    <= cmd.b;
			y_q    <= '0;
			rem_q  <= '0;
			bit_q  <= 64'h4000_0000_0000_0000;
		end else if (busy_q) begin
			if (sqrt_q) begin
				if (sq_ge) begin
					x_q <= x_q - trial;
					y_q <= (y_q >> 1) + bit_q;
				end else begin
					y_q <= y_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end else begin
				x_q   <= {x_q[62:0], 1'b0};
				rem_q <= rem_nx[31:0];
				y_q   <= {y_q[62:0], div_ge};
			end
		end
	end

	assign done   = done_q;
	assign result = y_q;

endmodule

// ----- src/spiral_sphere_point_generator.sv -----
// Top level: spiral sphere point generator with its sequencer and shared multiplier.
// Each accepted item (restart or advance) yields one point of a spiral of
// resolution^2+2 nearly evenly spread points on a sphere, with its unit normal
// (Q1.15), its index and a last flag; point coordinates are Q7.16 and saturate.
// Each item runs on the shared bit-serial divide / square-root unit, which
// runs two 32-step square roots and three divides of 55, 46 and 46 steps
// (at the two poles one root and two divides), and on a single registered
// 32x32 multiplier that also evaluates the sine polynomial. in_stall is
// high while an item is in work; a finished point waits in the output
// register, and the next item is taken meanwhile. Configuration registers
// are written through cfg_valid / cfg_index / cfg_data (always ready); the
// user must write them only while the block is idle: the block does not enforce it.
module spiral_sphere_point_generator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [23:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        restart,
	output logic        out_valid,
	input  logic        out_stall,
	output logic signed [23:0] point_x,
	output logic signed [23:0] point_y,
	output logic signed [23:0] point_z,
	output logic signed [15:0] normal_x,
	output logic signed [15:0] normal_y,
	output logic signed [15:0] normal_z,
	output logic [15:0] point_number,
	output logic        last_point
);
	import ssp_pkg::*;

	// Sequencer states
	localparam logic [4:0] ST_IDLE    = 5'd0;
	localparam logic [4:0] ST_NN      = 5'd1;
	localparam logic [4:0] ST_IDX     = 5'd2;
	localparam logic [4:0] ST_MK      = 5'd3;
	localparam logic [4:0] ST_MUL_MK  = 5'd4;
	localparam logic [4:0] ST_MUL_W   = 5'd5;
	localparam logic [4:0] ST_MUL_KN  = 5'd6;
	localparam logic [4:0] ST_AZ_SQ   = 5'd7;
	localparam logic [4:0] ST_AZ_SQW  = 5'd8;
	localparam logic [4:0] ST_AZ_DVW  = 5'd9;
	localparam logic [4:0] ST_SIN_SQ  = 5'd10;
	localparam logic [4:0] ST_SIN_SQW = 5'd11;
	localparam logic [4:0] ST_SIN_DVW = 5'd12;
	localparam logic [4:0] ST_H_DVW   = 5'd13;
	localparam logic [4:0] ST_SN0     = 5'd14;
	localparam logic [4:0] ST_SN1     = 5'd15;
	localparam logic [4:0] ST_SN2     = 5'd16;
	localparam logic [4:0] ST_SN3     = 5'd17;
	localparam logic [4:0] ST_SN4     = 5'd18;
	localparam logic [4:0] ST_SN5     = 5'd19;
	localparam logic [4:0] ST_SN6     = 5'd20;
	localparam logic [4:0] ST_NX      = 5'd21;
	localparam logic [4:0] ST_NY      = 5'd22;
	localparam logic [4:0] ST_P0      = 5'd23;
	localparam logic [4:0] ST_P1      = 5'd24;
	localparam logic [4:0] ST_P2      = 5'd25;
	localparam logic [4:0] ST_P3      = 5'd26;
	localparam logic [4:0] ST_FIN     = 5'd27;

	// Round a Q46 magnitude product to Q16, apply sign, add center, saturate
	function automatic logic [23:0] place(input logic [63:0] prod, input logic neg,
			input logic [23:0] cen);
		logic [63:0] rnd;
		logic [25:0] mag;
		logic [25:0] sum;
		begin
			rnd = prod + 64'h2000_0000;
			mag = {2'b00, rnd[53:30]};
			sum = {{2{cen[23]}}, cen} + (neg ? (26'd0 - mag) : mag);
			if (!sum[25] && (sum[24] || sum[23]))
				place = 24'h7F_FFFF;
			else if (sum[25] && !(sum[24] && sum[23]))
				place = 24'h80_0000;
			else
				place = sum[23:0];
		end
	endfunction

	// Scale a Q30 sign / magnitude to Q1.15 with rounding and saturation
	function automatic logic [15:0] to_q15(input logic neg, input logic [30:0] mag);
		logic [31:0] rnd;
		logic [16:0] r;
		begin
			rnd = {1'b0, mag} + 32'h4000;
			r   = rnd[31:15];
			if (neg)
				to_q15 = 16'(17'd0 - r);
			else if (r > 17'd32767)
				to_q15 = 16'h7FFF;
			else
				to_q15 = r[15:0];
		end
	endfunction

	// Configuration registers
	logic [7:0]  resolution_q;
	logic [22:0] radius_q;
	logic [23:0] cx_q;
	logic [23:0] cy_q;
	logic [23:0] cz_q;

	// Control state
	logic [4:0]  state_q;
	logic [15:0] next_idx_q;
	logic [31:0] acc_q;
	logic        cos_pass_q;
	logic        out_valid_q;

	// Per-item working registers
	logic        restart_q;
	logic [15:0] n_q;
	logic [15:0] nm1_q;
	logic [15:0] m_q;
	logic [15:0] k_q;
	logic        pole_q;
	logic        dneg_q;
	logic [15:0] dmag_q;
	logic [33:0] u_q;
	logic [47:0] w_q;
	logic [46:0] kn_q;
	logic [31:0] accn_q;
	logic [30:0] sint_q;
	logic [30:0] hmag_q;
	logic [1:0]  quad_q;
	logic [30:0] z_q;
	logic [30:0] z2_q;
	logic        sneg_q;
	logic [30:0] smag_q;
	logic        cneg_q;
	logic [30:0] cmag_q;
	logic [2:0]  dirn_q;
	logic [30:0] dirm_q [3];
	logic [23:0] pt_q [3];
	logic [63:0] mul_q;

	// Output register
	logic [23:0] px_q, py_q, pz_q;
	logic [15:0] nx_q, ny_q, nz_q;
	logic [15:0] num_q;
	logic        last_q;

	// Combinational helpers
	logic [7:0]  res_c;
	logic [15:0] n_c;
	logic [15:0] nm1_c;
	logic [16:0] two_m;
	logic [16:0] nm1_x;
	logic        dneg_c;
	logic [16:0] dmag_c;
	logic [31:0] ang;
	logic [30:0] z_c;
	logic [31:0] t_c;
	logic [33:0] tt;
	logic [30:0] sin_mag;
	logic [63:0] rnd_c;
	logic [31:0] mul_a, mul_b;
	logic        out_free;
	logic        last_c;
	logic [16:0] m_inc;

	ssp_pkg::dsq_cmd_t cmd;
	logic              dsq_done;
	logic [63:0]       dsq_res;

	ssp_divsqrt u_divsqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.done   (dsq_done),
		.result (dsq_res)
	);

	// Clamp resolution, derive counts and the point index
	always_comb begin
		if (resolution_q < MIN_RESOLUTION)
			res_c = MIN_RESOLUTION;
		else if (resolution_q > MAX_RESOLUTION)
			res_c = MAX_RESOLUTION;
		else
			res_c = resolution_q;
		n_c    = mul_q[15:0] + 16'd2;
		nm1_c  = mul_q[15:0] + 16'd1;
		two_m  = {m_q, 1'b0};
		nm1_x  = {1'b0, nm1_q};
		dneg_c = two_m < nm1_x;
		dmag_c = dneg_c ? nm1_x - two_m : two_m - nm1_x;
		last_c = m_q == nm1_q;
		m_inc  = {1'b0, m_q} + 17'd1;
	end

	// Sine argument folding and polynomial terms
	always_comb begin
		ang     = cos_pass_q ? accn_q + 32'h4000_0000 : accn_q;
		z_c     = ang[30] ? Q30_ONE - {1'b0, ang[29:0]} : {1'b0, ang[29:0]};
		tt      = mul_q[63:30];
		sin_mag = (tt > {3'b000, Q30_ONE}) ? Q30_ONE : tt[30:0];
		rnd_c   = mul_q + 64'h2000_0000;
		case (state_q)
			ST_SN2:  t_c = SIN_D - mul_q[61:30];
			ST_SN3:  t_c = SIN_C - mul_q[61:30];
			ST_SN4:  t_c = SIN_B - mul_q[61:30];
			ST_SN5:  t_c = SIN_A - mul_q[61:30];
			default: t_c = SIN_E;
		endcase
	end

	// Select multiplier operands
	always_comb begin
		case (state_q)
			ST_NN:     begin mul_a = {24'd0, res_c};  mul_b = {24'd0, res_c}; end
			ST_MUL_MK: begin mul_a = {16'd0, m_q};    mul_b = {16'd0, k_q}; end
			ST_MUL_W:  begin mul_a = {16'd0, n_q};    mul_b = mul_q[31:0]; end
			ST_MUL_KN: begin mul_a = AZ_STEP_K;       mul_b = {16'd0, nm1_q}; end
			ST_SN0:    begin mul_a = {1'b0, z_c};     mul_b = {1'b0, z_c}; end
			ST_SN1:    begin mul_a = mul_q[61:30];    mul_b = t_c; end
			ST_SN2, ST_SN3, ST_SN4: begin
				mul_a = {1'b0, z2_q};
				mul_b = t_c;
			end
			ST_SN5:    begin mul_a = {1'b0, z_q};     mul_b = t_c; end
			ST_NX:     begin mul_a = {1'b0, sint_q};  mul_b = {1'b0, cmag_q}; end
			ST_NY:     begin mul_a = {1'b0, sint_q};  mul_b = {1'b0, smag_q}; end
			ST_P0:     begin mul_a = {9'd0, radius_q}; mul_b = {1'b0, dirm_q[0]}; end
			ST_P1:     begin mul_a = {9'd0, radius_q}; mul_b = {1'b0, dirm_q[1]}; end
			ST_P2:     begin mul_a = {9'd0, radius_q}; mul_b = {1'b0, dirm_q[2]}; end
			default:   begin mul_a = '0;              mul_b = '0; end
		endcase
	end

	// Issue commands to the divide / square-root unit
	always_comb begin
		cmd = '0;
		case (state_q)
			ST_AZ_SQ: begin
				cmd.start   = !pole_q;
				cmd.is_sqrt = 1'b1;
				cmd.count   = SQRT_ITERS;
				cmd.a       = {w_q, 16'd0};
			end
			ST_AZ_SQW: begin
				cmd.start = dsq_done;
				cmd.count = DIV_AZ_ITERS;
				cmd.a     = {kn_q, 17'd0};
				cmd.b     = dsq_res[31:0];
			end
			ST_SIN_SQ: begin
				cmd.start   = 1'b1;
				cmd.is_sqrt = 1'b1;
				cmd.count   = SQRT_ITERS;
				cmd.a       = {u_q, 30'd0};
			end
			ST_SIN_SQW: begin
				cmd.start = dsq_done;
				cmd.count = DIV_Q_ITERS;
				cmd.a     = {dsq_res[30:0], 33'd0};
				cmd.b     = {16'd0, nm1_q};
			end
			ST_SIN_DVW: begin
				cmd.start = dsq_done;
				cmd.count = DIV_Q_ITERS;
				cmd.a     = {dmag_q, 48'd0};
				cmd.b     = {16'd0, nm1_q};
			end
			default: cmd = '0;
		endcase
	end

	assign out_free = !out_valid_q || !out_stall;

	// Sequencer, configuration and sequence state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			next_idx_q   <= '0;
			acc_q        <= '0;
			cos_pass_q   <= 1'b0;
			out_valid_q  <= 1'b0;
			resolution_q <= 8'd8;
			radius_q     <= 23'd32768;
			cx_q         <= '0;
			cy_q         <= '0;
			cz_q         <= '0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					CFG_RESOLUTION: resolution_q <= cfg_data[7:0];
					CFG_RADIUS:     radius_q     <= cfg_data[22:0];
					CFG_CENTER_X:   cx_q         <= cfg_data;
					CFG_CENTER_Y:   cy_q         <= cfg_data;
					CFG_CENTER_Z:   cz_q         <= cfg_data;
					default: ;
				endcase
			end
			// Raise the result when a point is stored, drop it once taken
			if (state_q == ST_FIN && out_free)
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE:    if (in_valid) state_q <= ST_NN;
				ST_NN:      state_q <= ST_IDX;
				ST_IDX:     state_q <= ST_MK;
				ST_MK:      state_q <= ST_MUL_MK;
				ST_MUL_MK:  state_q <= ST_MUL_W;
				ST_MUL_W:   state_q <= ST_MUL_KN;
				ST_MUL_KN:  state_q <= ST_AZ_SQ;
				ST_AZ_SQ:   state_q <= pole_q ? ST_SIN_SQ : ST_AZ_SQW;
				ST_AZ_SQW:  if (dsq_done) state_q <= ST_AZ_DVW;
				ST_AZ_DVW:  if (dsq_done) state_q <= ST_SIN_SQ;
				ST_SIN_SQ:  state_q <= ST_SIN_SQW;
				ST_SIN_SQW: if (dsq_done) state_q <= ST_SIN_DVW;
				ST_SIN_DVW: if (dsq_done) state_q <= ST_H_DVW;
				ST_H_DVW: begin
					if (dsq_done) begin
						state_q    <= ST_SN0;
						cos_pass_q <= 1'b0;
					end
				end
				ST_SN0:     state_q <= ST_SN1;
				ST_SN1:     state_q <= ST_SN2;
				ST_SN2:     state_q <= ST_SN3;
				ST_SN3:     state_q <= ST_SN4;
				ST_SN4:     state_q <= ST_SN5;
				ST_SN5:     state_q <= ST_SN6;
				ST_SN6: begin
					if (cos_pass_q) begin
						state_q <= ST_NX;
					end else begin
						state_q    <= ST_SN0;
						cos_pass_q <= 1'b1;
					end
				end
				ST_NX:      state_q <= ST_NY;
				ST_NY:      state_q <= ST_P0;
				ST_P0:      state_q <= ST_P1;
				ST_P1:      state_q <= ST_P2;
				ST_P2:      state_q <= ST_P3;
				ST_P3:      state_q <= ST_FIN;
				ST_FIN: begin
					if (out_free) begin
						state_q     <= ST_IDLE;
						next_idx_q  <= (m_inc >= {1'b0, n_q}) ? 16'd0 : m_inc[15:0];
						acc_q       <= pole_q ? 32'd0 : accn_q;
					end
				end
				default:    state_q <= ST_IDLE;
			endcase
		end
	end

	// Working datapath and output register
	always_ff @(posedge clk) begin
		mul_q <= {32'd0, mul_a} * {32'd0, mul_b};
		case (state_q)
			ST_IDLE: restart_q <= restart;
			ST_IDX: begin
				n_q   <= n_c;
				nm1_q <= nm1_c;
				m_q   <= (restart_q || next_idx_q >= n_c) ? 16'd0 : next_idx_q;
			end
			ST_MK: begin
				k_q    <= nm1_q - m_q;
				pole_q <= (m_q == 16'd0) || last_c;
				dneg_q <= dneg_c;
				dmag_q <= dmag_c[15:0];
			end
			ST_MUL_W:  u_q  <= {mul_q[31:0], 2'b00};
			ST_MUL_KN: w_q  <= mul_q[47:0];
			ST_AZ_SQ: begin
				kn_q <= mul_q[46:0];
				if (pole_q)
					accn_q <= '0;
			end
			ST_AZ_DVW: if (dsq_done) accn_q <= acc_q + dsq_res[31:0];
			ST_SIN_DVW: begin
				if (dsq_done)
					sint_q <= (dsq_res > {33'd0, Q30_ONE}) ? Q30_ONE : dsq_res[30:0];
			end
			ST_H_DVW: if (dsq_done) hmag_q <= dsq_res[30:0];
			ST_SN0: begin
				quad_q <= ang[31:30];
				z_q    <= z_c;
			end
			ST_SN1: z2_q <= mul_q[60:30];
			ST_SN6: begin
				if (cos_pass_q) begin
					cneg_q <= quad_q[1];
					cmag_q <= sin_mag;
				end else begin
					sneg_q <= quad_q[1];
					smag_q <= sin_mag;
				end
			end
			ST_NY: begin
				dirm_q[0] <= rnd_c[60:30];
				dirn_q[0] <= cneg_q;
			end
			ST_P0: begin
				dirm_q[1] <= rnd_c[60:30];
				dirn_q[1] <= sneg_q;
				dirm_q[2] <= hmag_q;
				dirn_q[2] <= dneg_q;
			end
			ST_P1: pt_q[0] <= place(mul_q, dirn_q[0], cx_q);
			ST_P2: pt_q[1] <= place(mul_q, dirn_q[1], cy_q);
			ST_P3: pt_q[2] <= place(mul_q, dirn_q[2], cz_q);
			ST_FIN: begin
				if (out_free) begin
					px_q   <= pt_q[0];
					py_q   <= pt_q[1];
					pz_q   <= pt_q[2];
					nx_q   <= (radius_q == '0) ? 16'd0 : to_q15(dirn_q[0], dirm_q[0]);
					ny_q   <= (radius_q == '0) ? 16'd0 : to_q15(dirn_q[1], dirm_q[1]);
					nz_q   <= (radius_q == '0) ? 16'd0 : to_q15(dirn_q[2], dirm_q[2]);
					num_q  <= m_q;
					last_q <= last_c;
				end
			end
			default: ;
		endcase
	end

	assign cfg_ready    = 1'b1;
	assign in_stall     = state_q != ST_IDLE;
	assign out_valid    = out_valid_q;
	assign point_x      = px_q;
	assign point_y      = py_q;
	assign point_z      = pz_q;
	assign normal_x     = nx_q;
	assign normal_y     = ny_q;
	assign normal_z     = nz_q;
	assign point_number = num_q;
	assign last_point   = last_q;

endmodule

// ----- src/ssp_checker.sv -----
// Port-level checks of the spiral sphere point generator, bound to the top level.
module ssp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic signed [23:0] point_x,
	input logic signed [15:0] normal_z,
	input logic [15:0] point_number,
	input logic        last_point
);

	// A held result keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(point_x) && $stable(point_number))
		else $error("result changed while stalled");

	// An accepted item blocks the input until its point is done
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input not stalled after item accepted");

	// The last point is the north pole
	a_last_north: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last_point |->
			point_number >= 16'd17 && (normal_z == 16'sh7FFF || normal_z == 16'sd0))
		else $error("last point not at north pole");

	// Point zero is the south pole
	a_first_south: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && point_number == 16'd0 |->
			!last_point && (normal_z == 16'sh8000 || normal_z == 16'sd0))
		else $error("first point not at south pole");

endmodule

bind spiral_sphere_point_generator ssp_checker u_ssp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_stall     (in_stall),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.point_x      (point_x),
	.normal_z     (normal_z),
	.point_number (point_number),
	.last_point   (last_point)
);
